// ===== design/deadline_ordered_task_queue_unit_defines.svh =====
// Assertion macros shared by the deadline-ordered task queue.
`ifndef DEADLINE_ORDERED_TASK_QUEUE_UNIT_DEFINES_SVH
`define DEADLINE_ORDERED_TASK_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DOTQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DOTQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dotq_pkg.sv =====
`timescale 1ns / 1ps
package dotq_pkg;

   // Request opcodes.
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_CANCEL  = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_DUP  = 2'd2;

   // Classified command kinds passed from front to back.
   localparam logic [1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [1:0] KIND_CANCEL  = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;
   localparam logic [1:0] KIND_NOP     = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  client_id;
      logic        task_command;
      logic [47:0] deadline;
      logic [47:0] now_time;
   } req_type;

   typedef struct packed {
      logic       released;
      logic [5:0] out_client;
      logic       out_command;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] client_id;
      logic       task_command;
   } cmd_type;

endpackage

// ===== design/dotq_fifo.sv =====
`timescale 1ns / 1ps
// Small flop-based command queue between the front and the back.
module dotq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty,
   output logic             full
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== design/dotq_front.sv =====
`timescale 1ns / 1ps
// Accepts requests and classifies them into back-end commands.
module dotq_front #(
   parameter int CLIENT_COUNT = 64,
   parameter int TIME_BITS    = 48
) (
   input  logic                  start,
   input  dotq_pkg::req_type     req_item,
   input  logic                  queue_full,
   output logic                  busy,
   output logic                  push,
   output dotq_pkg::cmd_type     push_cmd,
   output logic [TIME_BITS-1:0]  push_time
);
   logic client_ok;

   assign busy      = queue_full;
   assign push      = start && !queue_full;
   assign client_ok = (11'(req_item.client_id) < 11'(CLIENT_COUNT));

   // Decode the opcode; out-of-range clients and unused codes become no-ops.
   always_comb begin
      push_cmd.client_id    = req_item.client_id;
      push_cmd.task_command = req_item.task_command;
      push_time             = TIME_BITS'(req_item.deadline);
      unique case (req_item.opcode)
         dotq_pkg::OP_ENQUEUE: begin
            push_cmd.kind = client_ok ? dotq_pkg::KIND_ENQUEUE : dotq_pkg::KIND_NOP;
         end
         dotq_pkg::OP_CANCEL: begin
            push_cmd.kind = client_ok ? dotq_pkg::KIND_CANCEL : dotq_pkg::KIND_NOP;
         end
         dotq_pkg::OP_RELEASE: begin
            push_cmd.kind = dotq_pkg::KIND_RELEASE;
            push_time     = TIME_BITS'(req_item.now_time);
         end
         default: begin
            push_cmd.kind = dotq_pkg::KIND_NOP;
         end
      endcase
   end
endmodule

// ===== design/dotq_back.sv =====
`timescale 1ns / 1ps
// Sorted shift array of pending tasks; executes one command at a time.
module dotq_back #(
   parameter int QUEUE_DEPTH  = 64,
   parameter int CLIENT_COUNT = 64,
   parameter int TIME_BITS    = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  dotq_pkg::cmd_type     cmd,
   input  logic [TIME_BITS-1:0]  cmd_time,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   output dotq_pkg::rsp_type     rsp_item
);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CIDX_W = $clog2(CLIENT_COUNT);

   localparam logic STATE_IDLE    = 1'b0;
   localparam logic STATE_RELEASE = 1'b1;

   logic                 state_ff, state_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CLIENT_COUNT-1:0] queued_ff, queued_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   dotq_pkg::rsp_type    rsp_ff, rsp_in;

   logic [TIME_BITS-1:0] dl_ff  [QUEUE_DEPTH];
   logic [5:0]           cli_ff [QUEUE_DEPTH];
   logic                 cmdb_ff[QUEUE_DEPTH];
   logic [TIME_BITS-1:0] dl_in  [QUEUE_DEPTH];
   logic [5:0]           cli_in [QUEUE_DEPTH];
   logic                 cmdb_in[QUEUE_DEPTH];

   logic [QUEUE_DEPTH-1:0] valid, le, hit_upto;
   logic                   op_insert, op_remove, op_pop;
   logic                   expire0, expire1, full;
   logic [CIDX_W-1:0]      cidx, head_cidx;

   assign cidx      = CIDX_W'(cmd.client_id);
   assign head_cidx = CIDX_W'(cli_ff[0]);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign expire0   = (count_ff != '0) && (now_ff >= dl_ff[0]);
   assign expire1   = (count_ff > CNT_W'(1)) && (now_ff >= dl_ff[1]);
   assign cmd_pop   = (state_ff == STATE_IDLE) && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Per-cell compares: position of the new deadline and the cancel match.
   always_comb begin
      logic run;
      run = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         valid[i]    = (CNT_W'(i) < count_ff);
         le[i]       = valid[i] && (dl_ff[i] <= cmd_time);
         run         = run || (valid[i] && (cli_ff[i] == cmd.client_id));
         hit_upto[i] = run;
      end
   end

   // Command sequencing and result formation.
   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      count_in     = count_ff;
      queued_in    = queued_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      op_insert    = 1'b0;
      op_remove    = 1'b0;
      op_pop       = 1'b0;
      if (cmd_pop) begin
         unique case (cmd.kind)
            dotq_pkg::KIND_ENQUEUE: begin
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
               if (full) begin
                  rsp_in.status = dotq_pkg::STATUS_FULL;
               end else if (queued_ff[cidx]) begin
                  rsp_in.status = dotq_pkg::STATUS_DUP;
               end else begin
                  op_insert       = 1'b1;
                  count_in        = count_ff + 1'b1;
                  queued_in[cidx] = 1'b1;
               end
            end
            dotq_pkg::KIND_CANCEL: begin
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
               if (queued_ff[cidx]) begin
                  op_remove       = 1'b1;
                  count_in        = count_ff - 1'b1;
                  queued_in[cidx] = 1'b0;
               end
            end
            dotq_pkg::KIND_RELEASE: begin
               state_in = STATE_RELEASE;
               now_in   = cmd_time;
            end
            default: begin
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
            end
         endcase
      end else if (state_ff == STATE_RELEASE) begin
         rsp_valid_in = 1'b1;
         if (expire0) begin
            op_pop               = 1'b1;
            count_in             = count_ff - 1'b1;
            queued_in[head_cidx] = 1'b0;
            rsp_in.released      = 1'b1;
            rsp_in.out_client    = cli_ff[0];
            rsp_in.out_command   = cmdb_ff[0];
            rsp_in.last          = !expire1;
            if (!expire1) begin
               state_in = STATE_IDLE;
            end
         end else begin
            rsp_in.last = 1'b1;
            state_in    = STATE_IDLE;
         end
      end
   end

   // Next contents of each cell of the shift array.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         dl_in[i]   = dl_ff[i];
         cli_in[i]  = cli_ff[i];
         cmdb_in[i] = cmdb_ff[i];
         if (op_insert && !le[i]) begin
            if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
               dl_in[i]   = cmd_time;
               cli_in[i]  = cmd.client_id;
               cmdb_in[i] = cmd.task_command;
            end else begin
               dl_in[i]   = dl_ff[(i == 0) ? 0 : i - 1];
               cli_in[i]  = cli_ff[(i == 0) ? 0 : i - 1];
               cmdb_in[i] = cmdb_ff[(i == 0) ? 0 : i - 1];
            end
         end else if ((op_remove && hit_upto[i]) || op_pop) begin
            if (i < QUEUE_DEPTH - 1) begin
               dl_in[i]   = dl_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
               cli_in[i]  = cli_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
               cmdb_in[i] = cmdb_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      now_ff <= now_in;
      rsp_ff <= rsp_in;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         dl_ff[i]   <= dl_in[i];
         cli_ff[i]  <= cli_in[i];
         cmdb_ff[i] <= cmdb_in[i];
      end
   end
endmodule

// ===== design/deadline_ordered_task_queue_unit.sv =====
`timescale 1ns / 1ps
// Deadline-ordered task queue. A request beat is taken when start is high and
// busy is low; results come out one per cycle on rsp_valid and cannot be held
// off. Enqueue, cancel and unused opcodes give one result each: the front puts
// the command in the command queue and the shift array executes it and
// registers the result. A release first latches the time, then gives one result
// per expired task (or one result when none expired), limited by the single pop
// per cycle of the shift array. The two-entry command queue takes further
// requests while a release drains, until it is full.
`include "deadline_ordered_task_queue_unit_defines.svh"
module deadline_ordered_task_queue_unit #(
   parameter int QUEUE_DEPTH  = 64,
   parameter int CLIENT_COUNT = 64,
   parameter int TIME_BITS    = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  dotq_pkg::req_type  req_item,
   output logic               rsp_valid,
   output dotq_pkg::rsp_type  rsp_item
);
   localparam int CMD_W  = $bits(dotq_pkg::cmd_type);
   localparam int FIFO_W = CMD_W + TIME_BITS;

   logic                  push, pop, fifo_empty, fifo_full;
   dotq_pkg::cmd_type     push_cmd, head_cmd;
   logic [TIME_BITS-1:0]  push_time, head_time;
   logic [FIFO_W-1:0]     head_data;

   dotq_front #(
      .CLIENT_COUNT(CLIENT_COUNT),
      .TIME_BITS   (TIME_BITS)
   ) u_front (
      .start     (start),
      .req_item  (req_item),
      .queue_full(fifo_full),
      .busy      (busy),
      .push      (push),
      .push_cmd  (push_cmd),
      .push_time (push_time)
   );

   dotq_fifo #(
      .WIDTH(FIFO_W),
      .DEPTH(2)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_time, push_cmd}),
      .pop      (pop),
      .head_data(head_data),
      .empty    (fifo_empty),
      .full     (fifo_full)
   );

   assign head_cmd  = dotq_pkg::cmd_type'(head_data[CMD_W-1:0]);
   assign head_time = head_data[FIFO_W-1:CMD_W];

   dotq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CLIENT_COUNT(CLIENT_COUNT),
      .TIME_BITS   (TIME_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(!fifo_empty),
      .cmd      (head_cmd),
      .cmd_time (head_time),
      .cmd_pop  (pop),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   // An accepted beat is in the command queue on the next cycle.
   `DOTQ_ASSERT_NEXT(a_push_lands, start && !busy, !fifo_empty, "accepted beat lost")
   // Results without a released task always close their request.
   `DOTQ_ASSERT_SAME(a_plain_last, rsp_valid && !rsp_item.released, rsp_item.last, "plain result not last")
   // Released tasks always report an ok status.
   `DOTQ_ASSERT_SAME(a_release_ok, rsp_valid && rsp_item.released, rsp_item.status == dotq_pkg::STATUS_OK, "release with bad status")
endmodule

// ===== bench/deadline_ordered_task_queue_unit_tb.sv =====
`timescale 1ns / 1ps
module deadline_ordered_task_queue_unit_tb;

   localparam int DEPTH = 64;
   localparam int CYCLE_LIMIT = 400000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   dotq_pkg::req_type req_item;
   logic              rsp_valid;
   dotq_pkg::rsp_type rsp_item;

   // Shadow copy of the sorted queue, kept in deadline order.
   logic [47:0] sched_deadline[$];
   logic [5:0]  sched_client[$];
   logic        sched_command[$];
   logic        client_pending[64];

   dotq_pkg::rsp_type expected_rsp[$];
   int                fail_count;
   int                cycle_count;

   deadline_ordered_task_queue_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Cycle counter guards against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Work out the result beats that one request causes.
   function automatic void predict_queue_step(input dotq_pkg::req_type r);
      dotq_pkg::rsp_type res;
      int                pos;
      int                popped;
      res = '0;
      res.last = 1'b1;
      popped = 0;
      if (r.opcode == dotq_pkg::OP_ENQUEUE) begin
         if (sched_deadline.size() >= DEPTH) begin
            res.status = dotq_pkg::STATUS_FULL;
         end else if (client_pending[r.client_id]) begin
            res.status = dotq_pkg::STATUS_DUP;
         end else begin
            pos = 0;
            while (pos < sched_deadline.size() && sched_deadline[pos] <= r.deadline)
               pos++;
            sched_deadline.insert(pos, r.deadline);
            sched_client.insert(pos, r.client_id);
            sched_command.insert(pos, r.task_command);
            client_pending[r.client_id] = 1'b1;
         end
         expected_rsp.push_back(res);
      end else if (r.opcode == dotq_pkg::OP_CANCEL) begin
         if (client_pending[r.client_id]) begin
            for (int i = 0; i < sched_client.size(); i++) begin
               if (sched_client[i] == r.client_id) begin
                  sched_deadline.delete(i);
                  sched_client.delete(i);
                  sched_command.delete(i);
                  break;
               end
            end
            client_pending[r.client_id] = 1'b0;
         end
         expected_rsp.push_back(res);
      end else if (r.opcode == dotq_pkg::OP_RELEASE) begin
         while (sched_deadline.size() > 0 && r.now_time >= sched_deadline[0]) begin
            res = '0;
            res.released = 1'b1;
            res.out_client = sched_client[0];
            res.out_command = sched_command[0];
            client_pending[sched_client[0]] = 1'b0;
            void'(sched_deadline.pop_front());
            void'(sched_client.pop_front());
            void'(sched_command.pop_front());
            expected_rsp.push_back(res);
            popped++;
         end
         if (popped == 0) begin
            res = '0;
            res.last = 1'b1;
            expected_rsp.push_back(res);
         end else begin
            expected_rsp[$].last = 1'b1;
         end
      end else begin
         expected_rsp.push_back(res);
      end
   endfunction

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      dotq_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result beat %p", rsp_item);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_item.released !== want.released) begin
               $error("released exp %0h got %0h", want.released, rsp_item.released);
               fail_count++;
            end
            if (rsp_item.out_client !== want.out_client) begin
               $error("out_client exp %0h got %0h", want.out_client, rsp_item.out_client);
               fail_count++;
            end
            if (rsp_item.out_command !== want.out_command) begin
               $error("out_command exp %0h got %0h", want.out_command,
                      rsp_item.out_command);
               fail_count++;
            end
            if (rsp_item.status !== want.status) begin
               $error("status exp %0h got %0h", want.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.last !== want.last) begin
               $error("last exp %0h got %0h", want.last, rsp_item.last);
               fail_count++;
            end
         end
      end
   end

   // Send one request beat, then leave start low for a random gap.
   task automatic send_request(input dotq_pkg::req_type r);
      int gap;
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      predict_queue_step(r);
      start <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      repeat (gap) @(posedge clock);
   endtask

   function automatic dotq_pkg::req_type make_request(input logic [1:0] op,
                                                      input logic [5:0] cli,
                                                      input logic cmd,
                                                      input logic [47:0] dl,
                                                      input logic [47:0] now_t);
      dotq_pkg::req_type r;
      r.opcode = op;
      r.client_id = cli;
      r.task_command = cmd;
      r.deadline = dl;
      r.now_time = now_t;
      return r;
   endfunction

   function automatic logic [47:0] random_time();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic wait_drained();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Extremes, ties, duplicates, cancel and the unused opcode.
   task automatic test_directed();
      send_request(make_request(dotq_pkg::OP_RELEASE, 6'd0, 1'b0, '0, '0));
      send_request(make_request(dotq_pkg::OP_ENQUEUE, 6'd63, 1'b1, 48'hFFFF_FFFF_FFFF, '0));
      send_request(make_request(dotq_pkg::OP_ENQUEUE, 6'd0, 1'b0, 48'd0, '0));
      send_request(make_request(dotq_pkg::OP_ENQUEUE, 6'd5, 1'b1, 48'd100, '0));
      send_request(make_request(dotq_pkg::OP_ENQUEUE, 6'd6, 1'b0, 48'd100, '0));
      send_request(make_request(dotq_pkg::OP_ENQUEUE, 6'd5, 1'b0, 48'd7, '0));
      send_request(make_request(dotq_pkg::OP_CANCEL, 6'd6, 1'b0, '0, '0));
      send_request(make_request(dotq_pkg::OP_CANCEL, 6'd40, 1'b1, '1, '1));
      send_request(make_request(2'd3, 6'd63, 1'b1, '1, '1));
      send_request(make_request(dotq_pkg::OP_RELEASE, 6'd0, 1'b0, '0, 48'd99));
      send_request(make_request(dotq_pkg::OP_RELEASE, 6'd0, 1'b0, '0, 48'd100));
      send_request(make_request(dotq_pkg::OP_RELEASE, 6'd0, 1'b0, '0,
                                48'hFFFF_FFFF_FFFF));
      wait_drained();
   endtask

   // Fill the queue to its depth, hit the full status, then drain all 64.
   task automatic test_full_queue();
      for (int i = 0; i < DEPTH; i++)
         send_request(make_request(dotq_pkg::OP_ENQUEUE, 6'(i), 1'($urandom),
                                   48'($urandom_range(0, 15)), '0));
      send_request(make_request(dotq_pkg::OP_ENQUEUE, 6'd3, 1'b0, 48'd1, '0));
      send_request(make_request(dotq_pkg::OP_RELEASE, 6'd0, 1'b0, '0,
                                48'hFFFF_FFFF_FFFF));
      wait_drained();
   endtask

   // Random mix: half enqueues over all 64 clients, plus cancels, unused opcodes and releases over a moving clock.
   task automatic test_random_traffic();
      logic [47:0]       now_t;
      int                pick;
      dotq_pkg::req_type r;
      now_t = 48'd0;
      for (int n = 0; n < 300; n++) begin
         pick = $urandom_range(0, 99);
         now_t = now_t + 48'($urandom_range(0, 40));
         if (n % 100 == 50) begin
            send_request(make_request(dotq_pkg::OP_RELEASE, 6'($urandom), 1'($urandom),
                                      random_time(), random_time()));
         end else if (pick < 50) begin
            r = make_request(dotq_pkg::OP_ENQUEUE, 6'($urandom_range(0, 63)),
                             1'($urandom), now_t + 48'($urandom_range(0, 120)),
                             random_time());
            if ($urandom_range(0, 19) == 0) r.deadline = random_time();
            send_request(r);
         end else if (pick < 65) begin
            send_request(make_request(dotq_pkg::OP_CANCEL, 6'($urandom), 1'($urandom),
                                      random_time(), random_time()));
         end else if (pick < 95) begin
            send_request(make_request(dotq_pkg::OP_RELEASE, 6'($urandom), 1'($urandom),
                                      random_time(), now_t));
         end else begin
            send_request(make_request(2'd3, 6'($urandom), 1'($urandom),
                                      random_time(), random_time()));
         end
         // Once, halfway through, hold off until everything has come back.
         if (n == 150) wait_drained();
      end
   endtask

   initial begin
      fail_count = 0;
      cycle_count = 0;
      for (int i = 0; i < 64; i++) client_pending[i] = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_queue();
      test_random_traffic();
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
